>>> hdl/ccfh_pkg.sv
// shared types, opcodes and helpers for the cat command frame handler
// no dependencies; imported by every module in hdl/
package ccfh_pkg;

  localparam int BYTE_W   = 8;
  localparam int HZ_W     = 30;
  localparam int FREQ_W   = 31;
  localparam int KIND_W   = 3;
  localparam int MASK_W   = 8;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int HDR_LEN  = 4;
  localparam int CNT_W    = 3;
  localparam int BCD_W    = 36;
  localparam int SH_W     = 36;
  localparam int DAB_BITS = 3;
  localparam int FREAD_STEPS = 10;
  localparam int FSET_STEPS  = 9;
  localparam int STEP_W   = 4;
  localparam int IDX_W    = 3;

  // opcodes (fifth frame byte)
  localparam logic [7:0] OP_PTT_ON    = 8'h08;
  localparam logic [7:0] OP_PTT_OFF   = 8'h88;
  localparam logic [7:0] OP_VFO_SWAP  = 8'h81;
  localparam logic [7:0] OP_FREQ_SET  = 8'h01;
  localparam logic [7:0] OP_MODE_SET  = 8'h07;
  localparam logic [7:0] OP_FREQ_READ = 8'h03;
  localparam logic [7:0] OP_MEM_READ  = 8'hBB;
  localparam logic [7:0] OP_RX_STATUS = 8'hE7;
  localparam logic [7:0] OP_TX_STATUS = 8'hF7;

  localparam logic [7:0] ACK_BYTE  = 8'h00;
  localparam logic [7:0] MEM_MAGIC = 8'h78;
  localparam logic [7:0] MEM_FLAG  = 8'h20;
  localparam logic [7:0] NIB_MASK  = 8'h0f;

  // handler-present bits
  localparam int HB_PTT     = 0;
  localparam int HB_VFO     = 1;
  localparam int HB_GETFREQ = 2;
  localparam int HB_GETMODE = 3;
  localparam int HB_SMETER  = 4;
  localparam int HB_TXSTAT  = 5;
  localparam int HB_FREQSET = 6;
  localparam int HB_MODESET = 7;

  // register indexes (paddr[2])
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_MASK   = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] EV_REPLY = 3'd0;
  localparam logic [KIND_W-1:0] EV_PTT   = 3'd1;
  localparam logic [KIND_W-1:0] EV_VFO   = 3'd2;
  localparam logic [KIND_W-1:0] EV_FSET  = 3'd3;
  localparam logic [KIND_W-1:0] EV_MSET  = 3'd4;

  typedef enum logic [2:0] {
    CLS_PTT,
    CLS_VFO,
    CLS_FSET,
    CLS_MSET,
    CLS_FREAD,
    CLS_REPLY1,
    CLS_MEM
  } cls_t;

  typedef struct packed {
    cls_t              cls;
    logic              ptt;
    logic [BYTE_W-1:0] arg;
    logic [31:0]       frame;
    logic [3:0]        op_hi;
    logic [HZ_W-1:0]   hz;
    logic [BYTE_W-1:0] mode;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] reply;
    logic              ptt;
    logic [FREQ_W-1:0] freq;
    logic [BYTE_W-1:0] mode;
    logic              last;
  } res_t;

  // three double-dabble steps: adjust digits, shift one bit in, msb first
  function automatic logic [BCD_W-1:0] dabble3(input logic [BCD_W-1:0] bcd_in,
                                               input logic [DAB_BITS-1:0] bits);
    logic [BCD_W-1:0] b;
    b = bcd_in;
    for (int k = 0; k < DAB_BITS; k++) begin
      for (int d = 0; d < BCD_W / 4; d++) begin
        if (b[4*d +: 4] >= 4'd5) b[4*d +: 4] = b[4*d +: 4] + 4'd3;
      end
      b = {b[BCD_W-2:0], bits[DAB_BITS-1-k]};
    end
    return b;
  endfunction

endpackage

>>> hdl/cat_command_frame_handler.sv
// cat command frame handler: 5-byte frames in, events and reply bytes out
// throughput: one byte a cycle in while the queue has room; the back end finishes each command,
//   including its frequency set digit or 3-bit bcd conversion steps, before it pops the next
// reset: synchronous active-low rst_n; empties queue and frame count, enable=1, mask=0
// depends on ccfh_pkg, ccfh_front, ccfh_queue, ccfh_back
module cat_command_frame_handler #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  // input byte channel
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_rx_byte,
  input  logic [29:0]  in_current_freq_hz,
  input  logic [7:0]   in_current_mode,
  input  logic [7:0]   in_smeter_level,
  input  logic [7:0]   in_tx_status_byte,
  // result channel
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   out_event_kind,
  output logic [7:0]   out_reply_byte,
  output logic         out_ptt_on,
  output logic [30:0]  out_freq_value,
  output logic [7:0]   out_mode_value,
  output logic         out_last_of_run,
  // apb-style register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ccfh_pkg::*;

  logic              enabled_r;
  logic [MASK_W-1:0] mask_r;
  logic              reg_wr;

  q_stat_t q_stat;
  logic    q_push, q_pop;
  cmd_t    q_in, q_out;
  res_t    res;

  // register file: enable at 0x0, handler mask at 0x4
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
      mask_r    <= '0;
    end else if (reg_wr) begin
      if (paddr[2] == REG_ENABLE) enabled_r <= pwdata[0];
      else                        mask_r    <= pwdata[MASK_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_ENABLE) prdata = {{(PDATA_W-1){1'b0}}, enabled_r};
    else                        prdata = {{(PDATA_W-MASK_W){1'b0}}, mask_r};
  end

  // front end: frame assembly, opcode decode, handler-present gating
  ccfh_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .in_current_freq_hz (in_current_freq_hz),
    .in_current_mode    (in_current_mode),
    .in_smeter_level    (in_smeter_level),
    .in_tx_status_byte  (in_tx_status_byte),
    .enabled            (enabled_r),
    .handler_mask       (mask_r),
    .q_stat             (q_stat),
    .q_push             (q_push),
    .q_data             (q_in)
  );

  // decoupling queue: the front keeps taking bytes while the back emits
  ccfh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  // back end: conversions and one result beat per cycle into the output register while out_ready drains it
  ccfh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_event_kind  = res.kind;
  assign out_reply_byte  = res.reply;
  assign out_ptt_on      = res.ptt;
  assign out_freq_value  = res.freq;
  assign out_mode_value  = res.mode;
  assign out_last_of_run = res.last;

`ifndef NO_ASSERTIONS
  // the front must never push into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("command pushed into full queue");

  // a disabled block drops bytes and never raises a command
  a_disabled_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (!enabled_r && in_valid && in_ready) |-> !q_push)
    else $error("command raised while disabled");

  // an event beat is always followed by its ack, so it never ends a run
  a_event_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind != EV_REPLY) |-> !out_last_of_run)
    else $error("event beat marked last of run");
`endif

endmodule

>>> hdl/ccfh_front.sv
// front end: gathers bytes into frames and classifies the opcode
// depends on ccfh_pkg; pushes one command per answered frame into the queue
module ccfh_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  input  logic [29:0]                     in_current_freq_hz,
  input  logic [7:0]                      in_current_mode,
  input  logic [7:0]                      in_smeter_level,
  input  logic [7:0]                      in_tx_status_byte,
  input  logic                            enabled,
  input  logic [7:0]                      handler_mask,
  input  ccfh_pkg::q_stat_t               q_stat,
  output logic                            q_push,
  output ccfh_pkg::cmd_t                  q_data
);
  import ccfh_pkg::*;

  logic [BYTE_W-1:0] fb_r [HDR_LEN];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              take;
  logic              present;

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready && enabled;

  always_comb begin
    if (cnt_r == CNT_W'(HDR_LEN)) cnt_nxt = '0;
    else                          cnt_nxt = cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (take) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && cnt_r != CNT_W'(HDR_LEN)) fb_r[cnt_r[1:0]] <= in_rx_byte;
  end

  // opcode decode
  always_comb begin
    q_data.cls   = CLS_REPLY1;
    q_data.ptt   = 1'b0;
    q_data.arg   = ACK_BYTE;
    q_data.frame = {fb_r[0], fb_r[1], fb_r[2], fb_r[3]};
    q_data.op_hi = in_rx_byte[7:4];
    q_data.hz    = in_current_freq_hz;
    q_data.mode  = in_current_mode;
    present      = 1'b1;
    case (in_rx_byte)
      OP_PTT_ON, OP_PTT_OFF: begin
        q_data.cls = CLS_PTT;
        q_data.ptt = (in_rx_byte == OP_PTT_ON);
        present    = handler_mask[HB_PTT];
      end
      OP_VFO_SWAP: begin
        q_data.cls = CLS_VFO;
        present    = handler_mask[HB_VFO];
      end
      OP_FREQ_SET: begin
        q_data.cls = CLS_FSET;
        present    = handler_mask[HB_FREQSET];
      end
      OP_MODE_SET: begin
        q_data.cls = CLS_MSET;
        present    = handler_mask[HB_MODESET];
      end
      OP_FREQ_READ: begin
        q_data.cls = CLS_FREAD;
        present    = handler_mask[HB_GETFREQ] && handler_mask[HB_GETMODE];
      end
      OP_MEM_READ: begin
        q_data.cls = CLS_MEM;
        if (handler_mask[HB_GETMODE] && fb_r[1] == MEM_MAGIC && in_current_mode != '0)
          q_data.arg = MEM_FLAG;
      end
      OP_RX_STATUS: begin
        q_data.arg = in_smeter_level & NIB_MASK;
        present    = handler_mask[HB_SMETER];
      end
      OP_TX_STATUS: begin
        q_data.arg = in_tx_status_byte;
        present    = handler_mask[HB_TXSTAT];
      end
      default: begin
        q_data.arg = ACK_BYTE;
      end
    endcase
  end

  assign q_push = take && cnt_r == CNT_W'(HDR_LEN) && present;

endmodule

>>> hdl/ccfh_queue.sv
// short command queue between front and back end
// depends on ccfh_pkg for the command type
module ccfh_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ccfh_pkg::cmd_t     push_data,
  input  logic               pop,
  output ccfh_pkg::cmd_t     pop_data,
  output ccfh_pkg::q_stat_t  stat
);
  import ccfh_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QCNT_W = $clog2(DEPTH + 1);

  cmd_t              mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (count_r == QCNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

>>> hdl/ccfh_back.sv
// back end: bcd conversion, frequency decode and result sequencing
// depends on ccfh_pkg; drains ccfh_queue and drives the output register
module ccfh_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ccfh_pkg::q_stat_t  q_stat,
  input  ccfh_pkg::cmd_t     q_data,
  output logic               q_pop,
  input  logic               out_ready,
  output logic               out_valid,
  output ccfh_pkg::res_t     res
);
  import ccfh_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_t;

  state_t            state_r;
  cmd_t              cmd_r;
  logic [SH_W-1:0]   sh_r, sh_nxt;
  logic [BCD_W-1:0]  acc_r, acc_nxt;
  logic [STEP_W-1:0] cnt_r;
  logic [IDX_W-1:0]  idx_r;
  logic              out_valid_r;
  res_t              res_r, res_nxt;
  logic              conv_last;
  logic              slot_free;
  logic [FREQ_W-1:0] f10;

  assign q_pop     = (state_r == ST_IDLE) && !q_stat.empty;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  // one conversion step
  always_comb begin
    f10 = {acc_r[FREQ_W-4:0], 3'b000} + {acc_r[FREQ_W-2:0], 1'b0};
    if (cmd_r.cls == CLS_FREAD) begin
      acc_nxt   = dabble3(acc_r, sh_r[SH_W-1 -: DAB_BITS]);
      sh_nxt    = {sh_r[SH_W-DAB_BITS-1:0], {DAB_BITS{1'b0}}};
      conv_last = (cnt_r == STEP_W'(FREAD_STEPS - 1));
    end else begin
      acc_nxt   = {{(BCD_W-FREQ_W){1'b0}}, f10 + {{(FREQ_W-4){1'b0}}, sh_r[SH_W-1 -: 4]}};
      sh_nxt    = {sh_r[SH_W-5:0], 4'b0000};
      conv_last = (cnt_r == STEP_W'(FSET_STEPS - 1));
    end
  end

  // result for the current position in the sequence
  always_comb begin
    res_nxt       = '0;
    res_nxt.kind  = EV_REPLY;
    res_nxt.reply = ACK_BYTE;
    case (cmd_r.cls)
      CLS_PTT: begin
        if (idx_r == '0) begin
          res_nxt.kind = EV_PTT;
          res_nxt.ptt  = cmd_r.ptt;
        end else res_nxt.last = 1'b1;
      end
      CLS_VFO: begin
        if (idx_r == '0) res_nxt.kind = EV_VFO;
        else             res_nxt.last = 1'b1;
      end
      CLS_FSET: begin
        if (idx_r == '0) begin
          res_nxt.kind = EV_FSET;
          res_nxt.freq = acc_r[FREQ_W-1:0];
        end else res_nxt.last = 1'b1;
      end
      CLS_MSET: begin
        if (idx_r == '0) begin
          res_nxt.kind = EV_MSET;
          res_nxt.mode = cmd_r.frame[31:24];
        end else res_nxt.last = 1'b1;
      end
      CLS_FREAD: begin
        // hz digits two and up are the digits of hz/100
        case (idx_r)
          3'd0:    res_nxt.reply = acc_r[35:28];
          3'd1:    res_nxt.reply = acc_r[27:20];
          3'd2:    res_nxt.reply = acc_r[19:12];
          3'd3:    res_nxt.reply = {acc_r[11:8], 4'b0000};
          default: begin
            res_nxt.reply = cmd_r.mode;
            res_nxt.last  = 1'b1;
          end
        endcase
      end
      CLS_MEM: begin
        if (idx_r == '0) res_nxt.reply = cmd_r.arg;
        else             res_nxt.last  = 1'b1;
      end
      CLS_REPLY1: begin
        res_nxt.reply = cmd_r.arg;
        res_nxt.last  = 1'b1;
      end
      default: begin
        res_nxt.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
    end else begin
      // a new beat loads the output register, otherwise an accepted beat empties it
      if (state_r == ST_EMIT && slot_free) out_valid_r <= 1'b1;
      else if (out_ready)                  out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            cmd_r <= q_data;
            cnt_r <= '0;
            idx_r <= '0;
            acc_r <= '0;
            if (q_data.cls == CLS_FREAD)
              sh_r <= {q_data.hz, {(SH_W-HZ_W){1'b0}}};
            else
              sh_r <= {q_data.frame, q_data.op_hi};
            if (q_data.cls == CLS_FREAD || q_data.cls == CLS_FSET) state_r <= ST_CONV;
            else                                                  state_r <= ST_EMIT;
          end
        end
        ST_CONV: begin
          acc_r <= acc_nxt;
          sh_r  <= sh_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (conv_last) state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            res_r <= res_nxt;
            if (res_nxt.last) begin
              state_r <= ST_IDLE;
              idx_r   <= '0;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
